### sv/java_bytecode_integer_core_assert.svh
// assertion macros shared by the java bytecode integer core modules
// expects clk_i and rst_ni in the including module's scope
`ifndef JAVA_BYTECODE_INTEGER_CORE_ASSERT_SVH
`define JAVA_BYTECODE_INTEGER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define JBIC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("jbic assertion failed");
`define JBIC_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("jbic forbidden condition seen");
`else
`define JBIC_ASSERT(lbl, prop)
`define JBIC_NEVER(lbl, expr)
`endif
`endif

### sv/jbic_pkg.sv
// shared types and constants of the java bytecode integer core
// no dependencies
package jbic_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned LOCAL_COUNT = 16;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned LIDX_W      = $clog2(LOCAL_COUNT);
  localparam int unsigned ENTRY_W     = 33;
  localparam int unsigned XLEN        = 32;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         opcode;
    logic [39:0]        following_bytes;
    logic [7:0]         local_index;
    logic signed [31:0] local_value;
    logic               local_is_ref;
  } in_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic [2:0]         status;
    logic signed [31:0] return_value;
  } out_t;

  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_REM, ALU_SHL, ALU_SHR, ALU_USHR,
    ALU_AND, ALU_OR, ALU_XOR, ALU_CMP
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_CONT, ST_RET, ST_OVF, ST_DIV0, ST_THROWN, ST_UNSUP, ST_BAD_LOCAL
  } status_e;

  typedef enum logic [2:0] {
    SRC_V1, SRC_V2, SRC_V3, SRC_V4, SRC_RES
  } src_e;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_READ, S_EXEC, S_WAIT, S_FIN, S_WRITE, S_OUT
  } state_e;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_EXEC  = 2'd2;

endpackage

### sv/jbic_stack.sv
// operand stack memory of the java bytecode integer core
// one write port, one registered read port; uses jbic_pkg
module jbic_stack (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [jbic_pkg::ADDR_W-1:0]       waddr_i,
  input  logic [jbic_pkg::ENTRY_W-1:0]      wdata_i,
  input  logic [jbic_pkg::ADDR_W-1:0]       raddr_i,
  output logic [jbic_pkg::ENTRY_W-1:0]      rdata_o
);

  logic [jbic_pkg::ENTRY_W-1:0] mem_q [jbic_pkg::STACK_DEPTH];
  logic [jbic_pkg::ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/jbic_alu.sv
// shared arithmetic unit: registered simple ops and a bit-serial signed divider
// uses jbic_pkg and the assertion macro header
`include "java_bytecode_integer_core_assert.svh"
module jbic_alu (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  jbic_pkg::alu_op_e      op_i,
  input  logic [31:0]            a_i,
  input  logic [31:0]            b_i,
  output logic                   done_o,
  output logic [31:0]            res_o
);

  localparam int unsigned CNT_W = $clog2(jbic_pkg::XLEN + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [31:0]      res_q, quo_q, rem_q, dvs_q;
  logic             qneg_q, rneg_q, isrem_q;
  logic             is_div, last;
  logic [32:0]      trial, diff;
  logic [31:0]      mag_a, mag_b, simple;

  assign is_div = (op_i == jbic_pkg::ALU_DIV) || (op_i == jbic_pkg::ALU_REM);
  assign last   = (cnt_q == CNT_W'(jbic_pkg::XLEN));
  assign mag_a  = a_i[31] ? (32'd0 - a_i) : a_i;
  assign mag_b  = b_i[31] ? (32'd0 - b_i) : b_i;
  assign trial  = {rem_q, quo_q[31]};
  assign diff   = trial - {1'b0, dvs_q};

  always_comb begin
    case (op_i)
      jbic_pkg::ALU_ADD:  simple = a_i + b_i;
      jbic_pkg::ALU_SUB:  simple = a_i - b_i;
      jbic_pkg::ALU_MUL:  simple = a_i * b_i;
      jbic_pkg::ALU_SHL:  simple = a_i << b_i[4:0];
      jbic_pkg::ALU_SHR:  simple = 32'($signed(a_i) >>> b_i[4:0]);
      jbic_pkg::ALU_USHR: simple = a_i >> b_i[4:0];
      jbic_pkg::ALU_AND:  simple = a_i & b_i;
      jbic_pkg::ALU_OR:   simple = a_i | b_i;
      jbic_pkg::ALU_XOR:  simple = a_i ^ b_i;
      jbic_pkg::ALU_CMP: begin
        if ($signed(a_i) < $signed(b_i)) simple = 32'hFFFF_FFFF;
        else if (a_i == b_i)             simple = 32'd0;
        else                             simple = 32'd1;
      end
      default:            simple = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (is_div) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end else begin
          done_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      res_q   <= simple;
      quo_q   <= mag_a;
      rem_q   <= 32'd0;
      dvs_q   <= mag_b;
      qneg_q  <= a_i[31] ^ b_i[31];
      rneg_q  <= a_i[31];
      isrem_q <= (op_i == jbic_pkg::ALU_REM);
    end else if (busy_q) begin
      if (last) begin
        if (isrem_q) res_q <= rneg_q ? (32'd0 - rem_q) : rem_q;
        else         res_q <= qneg_q ? (32'd0 - quo_q) : quo_q;
      end else begin
        rem_q <= diff[32] ? trial[31:0] : diff[31:0];
        quo_q <= {quo_q[30:0], ~diff[32]};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `JBIC_NEVER(a_start_while_busy, start_i && busy_q)
  `JBIC_NEVER(a_done_while_busy, done_q && busy_q)
  `JBIC_ASSERT(a_count_from_zero, $rose(busy_q) |-> cnt_q == '0)

endmodule

### sv/java_bytecode_integer_core.sv
// top level of the java bytecode integer core: sequencer, locals, pc, output register
// uses jbic_pkg, jbic_stack, jbic_alu and the assertion macro header
//
// usage: each input item (in_i, in_valid_i / in_stall_o) clears the frame, loads one
// argument into a local, or executes one bytecode given with its next five code bytes.
// every item gives exactly one result item (out_o, out_valid_o / out_stall_i) with the
// next pc, a status and a return value. the user is to write code_length through
// cfg_we_i and cfg_wdata_i only while the block is idle; the block does not check it.
// one item is worked at a time; in_stall_o is high from acceptance until the result is
// moved into the output register. clear, load and past-the-end execute go from decode
// straight to the output state. an executed bytecode passes read, exec, wait and fin
// states and, if it pushes, the write state. stack entries are read one at a time
// through the single stack read port and pushed one at a time through its write port
// (at most 4 reads, 6 pushes); div/rem wait on the shared alu's bit-serial divider.
// the output register holds a result while out_stall_i is high and the next item may be
// accepted meanwhile; that item then waits for the register before it completes.
// reset empties the stack, zeroes all locals, pc and code_length; no clearing pass.
`include "java_bytecode_integer_core_assert.svh"
module java_bytecode_integer_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  jbic_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output jbic_pkg::out_t  out_o,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i
);

  localparam int unsigned DW = jbic_pkg::DEPTH_W;
  localparam int unsigned AW = jbic_pkg::ADDR_W;
  localparam int unsigned EW = jbic_pkg::ENTRY_W;
  localparam int unsigned LW = jbic_pkg::LIDX_W;
  localparam logic [EW-1:0] REF_NULL = {1'b1, 32'd0};

  localparam logic [7:0] OP_NOP = 8'h00, OP_ACONST_NULL = 8'h01, OP_ICONST_M1 = 8'h02;
  localparam logic [7:0] OP_ICONST_0 = 8'h03, OP_ICONST_5 = 8'h08;
  localparam logic [7:0] OP_LCONST_0 = 8'h09, OP_LCONST_1 = 8'h0a;
  localparam logic [7:0] OP_FCONST_0 = 8'h0b, OP_FCONST_2 = 8'h0d;
  localparam logic [7:0] OP_DCONST_0 = 8'h0e, OP_DCONST_1 = 8'h0f;
  localparam logic [7:0] OP_BIPUSH = 8'h10, OP_SIPUSH = 8'h11;
  localparam logic [7:0] OP_ILOAD = 8'h15, OP_ALOAD = 8'h19;
  localparam logic [7:0] OP_ILOAD_0 = 8'h1a, OP_ALOAD_3 = 8'h2d;
  localparam logic [7:0] OP_ISTORE = 8'h36, OP_ASTORE = 8'h3a;
  localparam logic [7:0] OP_ISTORE_0 = 8'h3b, OP_ASTORE_3 = 8'h4e;
  localparam logic [7:0] OP_POP = 8'h57, OP_POP2 = 8'h58, OP_DUP = 8'h59;
  localparam logic [7:0] OP_DUP_X1 = 8'h5a, OP_DUP_X2 = 8'h5b, OP_DUP2 = 8'h5c;
  localparam logic [7:0] OP_DUP2_X1 = 8'h5d, OP_DUP2_X2 = 8'h5e, OP_SWAP = 8'h5f;
  localparam logic [7:0] OP_IADD = 8'h60, OP_ISUB = 8'h64, OP_IMUL = 8'h68;
  localparam logic [7:0] OP_IDIV = 8'h6c, OP_IREM = 8'h70, OP_INEG = 8'h74;
  localparam logic [7:0] OP_DNEG = 8'h77, OP_ISHL = 8'h78, OP_ISHR = 8'h7a;
  localparam logic [7:0] OP_IUSHR = 8'h7c, OP_IAND = 8'h7e, OP_IOR = 8'h80;
  localparam logic [7:0] OP_IXOR = 8'h82, OP_LXOR = 8'h83, OP_IINC = 8'h84;
  localparam logic [7:0] OP_I2L = 8'h85, OP_D2F = 8'h90;
  localparam logic [7:0] OP_I2B = 8'h91, OP_I2C = 8'h92, OP_I2S = 8'h93;
  localparam logic [7:0] OP_LCMP = 8'h94, OP_DCMPG = 8'h98;
  localparam logic [7:0] OP_IFEQ = 8'h99, OP_IFLE = 8'h9e;
  localparam logic [7:0] OP_IF_ICMPEQ = 8'h9f, OP_IF_ICMPLE = 8'ha4;
  localparam logic [7:0] OP_IF_ACMPEQ = 8'ha5, OP_IF_ACMPNE = 8'ha6;
  localparam logic [7:0] OP_GOTO = 8'ha7, OP_JSR = 8'ha8, OP_RET = 8'ha9;
  localparam logic [7:0] OP_IRETURN = 8'hac, OP_ARETURN = 8'hb0, OP_RETURN = 8'hb1;
  localparam logic [7:0] OP_ATHROW = 8'hbf, OP_WIDE = 8'hc4;
  localparam logic [7:0] OP_IFNULL = 8'hc6, OP_IFNONNULL = 8'hc7, OP_GOTO_W = 8'hc8;

  localparam logic [2:0] CND_EQ = 3'd0, CND_NE = 3'd1, CND_LT = 3'd2;
  localparam logic [2:0] CND_GE = 3'd3, CND_GT = 3'd4;

  function automatic logic cond_take(logic [2:0] sel, logic [31:0] c);
    logic neg, zero;
    neg  = c[31];
    zero = (c == 32'd0);
    case (sel)
      CND_EQ:  return zero;
      CND_NE:  return !zero;
      CND_LT:  return neg;
      CND_GE:  return !neg;
      CND_GT:  return !neg && !zero;
      default: return neg || zero;
    endcase
  endfunction

  jbic_pkg::state_e  state_q, state_d;
  jbic_pkg::in_t     item_q;
  jbic_pkg::out_t    rsp_q, out_q;
  logic              out_valid_q;
  logic [15:0]       code_len_q, pc_q;
  logic [DW-1:0]     depth_q, dpop_q, dpop;
  logic [EW-1:0]     loc_q [jbic_pkg::LOCAL_COUNT];
  logic [EW-1:0]     v_q [4];
  logic [EW-1:0]     res_q, res, lval, lwdata, stk_wdata, stk_rdata;
  logic [2:0]        rcnt_q, wcnt_q, np_q, nread, npop, np;
  jbic_pkg::src_e    src [8];
  jbic_pkg::alu_op_e alu_op;
  logic [31:0]       alu_a, alu_b, alu_res, retv;
  logic              alu_start, alu_done;
  jbic_pkg::status_e fault, st;
  logic              is_ret, lwe, br, take, lok, ovf, stk_we, out_load;
  logic [15:0]       nxt, li;
  logic [7:0]        op, bt0, bt1, bt2, bt3, bt4, wop;
  logic [AW-1:0]     stk_waddr, stk_raddr;

  assign op  = item_q.opcode;
  assign bt0 = item_q.following_bytes[39:32];
  assign bt1 = item_q.following_bytes[31:24];
  assign bt2 = item_q.following_bytes[23:16];
  assign bt3 = item_q.following_bytes[15:8];
  assign bt4 = item_q.following_bytes[7:0];
  assign wop = bt0;

  always_comb begin
    if (op == OP_WIDE)                              li = {bt1, bt2};
    else if (op >= OP_ILOAD_0 && op <= OP_ALOAD_3)  li = 16'((op - OP_ILOAD_0) & 8'd3);
    else if (op >= OP_ISTORE_0 && op <= OP_ASTORE_3) li = 16'((op - OP_ISTORE_0) & 8'd3);
    else                                            li = {8'd0, bt0};
  end

  assign lok  = (17'(li) < 17'(jbic_pkg::LOCAL_COUNT));
  assign lval = loc_q[li[LW-1:0]];

  always_comb begin
    nread  = '0;
    npop   = '0;
    np     = '0;
    for (int k = 0; k < 8; k++) src[k] = jbic_pkg::SRC_RES;
    alu_op = jbic_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    res    = '0;
    fault  = jbic_pkg::ST_CONT;
    is_ret = 1'b0;
    retv   = '0;
    nxt    = pc_q + 16'd1;
    lwe    = 1'b0;
    lwdata = v_q[0];
    br     = 1'b0;
    take   = 1'b0;
    if (op == OP_NOP || (op >= OP_I2L && op <= OP_D2F)) begin
      np = '0;
    end else if (op == OP_ACONST_NULL) begin
      np  = 3'd1;
      res = REF_NULL;
    end else if (op >= OP_ICONST_M1 && op <= OP_ICONST_5) begin
      np  = 3'd1;
      res = {1'b0, 32'(op) - 32'(OP_ICONST_0)};
    end else if (op >= OP_LCONST_0 && op <= OP_LCONST_1) begin
      np  = 3'd1;
      res = {1'b0, 32'(op - OP_LCONST_0)};
    end else if (op >= OP_FCONST_0 && op <= OP_FCONST_2) begin
      np  = 3'd1;
      res = {1'b0, 32'(op - OP_FCONST_0)};
    end else if (op >= OP_DCONST_0 && op <= OP_DCONST_1) begin
      np  = 3'd1;
      res = {1'b0, 32'(op - OP_DCONST_0)};
    end else if (op == OP_BIPUSH) begin
      np  = 3'd1;
      res = {1'b0, {24{bt0[7]}}, bt0};
      nxt = pc_q + 16'd2;
    end else if (op == OP_SIPUSH) begin
      np  = 3'd1;
      res = {1'b0, {16{bt0[7]}}, bt0, bt1};
      nxt = pc_q + 16'd3;
    end else if (op >= OP_ILOAD && op <= OP_ALOAD) begin
      np  = {2'b0, lok};
      res = lval;
      if (!lok) fault = jbic_pkg::ST_BAD_LOCAL;
      nxt = pc_q + 16'd2;
    end else if (op >= OP_ILOAD_0 && op <= OP_ALOAD_3) begin
      np  = 3'd1;
      res = lval;
    end else if (op >= OP_ISTORE && op <= OP_ASTORE) begin
      nread = 3'd1;
      npop  = 3'd1;
      lwe   = lok;
      if (!lok) fault = jbic_pkg::ST_BAD_LOCAL;
      nxt   = pc_q + 16'd2;
    end else if (op >= OP_ISTORE_0 && op <= OP_ASTORE_3) begin
      nread = 3'd1;
      npop  = 3'd1;
      lwe   = 1'b1;
    end else if (op == OP_POP) begin
      nread = 3'd1;
      npop  = 3'd1;
    end else if (op == OP_POP2) begin
      nread = 3'd2;
      npop  = 3'd2;
    end else if (op == OP_DUP) begin
      nread  = 3'd1;
      np     = 3'd1;
      src[0] = jbic_pkg::SRC_V1;
    end else if (op == OP_DUP_X1) begin
      nread  = 3'd2;
      npop   = 3'd2;
      np     = 3'd3;
      src[0] = jbic_pkg::SRC_V1;
      src[1] = jbic_pkg::SRC_V2;
      src[2] = jbic_pkg::SRC_V1;
    end else if (op == OP_DUP_X2) begin
      nread  = 3'd3;
      npop   = 3'd3;
      np     = 3'd4;
      src[0] = jbic_pkg::SRC_V1;
      src[1] = jbic_pkg::SRC_V3;
      src[2] = jbic_pkg::SRC_V2;
      src[3] = jbic_pkg::SRC_V1;
    end else if (op == OP_DUP2) begin
      nread  = 3'd2;
      npop   = 3'd2;
      np     = 3'd4;
      src[0] = jbic_pkg::SRC_V2;
      src[1] = jbic_pkg::SRC_V1;
      src[2] = jbic_pkg::SRC_V2;
      src[3] = jbic_pkg::SRC_V1;
    end else if (op == OP_DUP2_X1) begin
      nread  = 3'd3;
      npop   = 3'd3;
      np     = 3'd5;
      src[0] = jbic_pkg::SRC_V2;
      src[1] = jbic_pkg::SRC_V1;
      src[2] = jbic_pkg::SRC_V3;
      src[3] = jbic_pkg::SRC_V2;
      src[4] = jbic_pkg::SRC_V1;
    end else if (op == OP_DUP2_X2) begin
      nread  = 3'd4;
      npop   = 3'd4;
      np     = 3'd6;
      src[0] = jbic_pkg::SRC_V2;
      src[1] = jbic_pkg::SRC_V1;
      src[2] = jbic_pkg::SRC_V4;
      src[3] = jbic_pkg::SRC_V3;
      src[4] = jbic_pkg::SRC_V2;
      src[5] = jbic_pkg::SRC_V1;
    end else if (op == OP_SWAP) begin
      nread  = 3'd2;
      npop   = 3'd2;
      np     = 3'd2;
      src[0] = jbic_pkg::SRC_V1;
      src[1] = jbic_pkg::SRC_V2;
    end else if (op >= OP_INEG && op <= OP_DNEG) begin
      nread  = 3'd1;
      npop   = 3'd1;
      np     = 3'd1;
      alu_op = jbic_pkg::ALU_SUB;
      alu_b  = v_q[0][31:0];
      res    = {1'b0, alu_res};
    end else if (op >= OP_IADD && op <= OP_LXOR) begin
      nread = 3'd2;
      npop  = 3'd2;
      np    = 3'd1;
      alu_a = v_q[1][31:0];
      alu_b = v_q[0][31:0];
      res   = {1'b0, alu_res};
      if (op < OP_ISUB)       alu_op = jbic_pkg::ALU_ADD;
      else if (op < OP_IMUL)  alu_op = jbic_pkg::ALU_SUB;
      else if (op < OP_IDIV)  alu_op = jbic_pkg::ALU_MUL;
      else if (op < OP_IREM)  alu_op = jbic_pkg::ALU_DIV;
      else if (op < OP_INEG)  alu_op = jbic_pkg::ALU_REM;
      else if (op < OP_ISHR)  alu_op = jbic_pkg::ALU_SHL;
      else if (op < OP_IUSHR) alu_op = jbic_pkg::ALU_SHR;
      else if (op < OP_IAND)  alu_op = jbic_pkg::ALU_USHR;
      else if (op < OP_IOR)   alu_op = jbic_pkg::ALU_AND;
      else if (op < OP_IXOR)  alu_op = jbic_pkg::ALU_OR;
      else                    alu_op = jbic_pkg::ALU_XOR;
      if (op >= OP_IDIV && op < OP_INEG && v_q[0][31:0] == 32'd0) begin
        fault = jbic_pkg::ST_DIV0;
        np    = '0;
      end
    end else if (op == OP_IINC) begin
      alu_a  = lval[31:0];
      alu_b  = {{24{bt1[7]}}, bt1};
      lwe    = lok;
      lwdata = {lval[32], alu_res};
      if (!lok) fault = jbic_pkg::ST_BAD_LOCAL;
      nxt    = pc_q + 16'd3;
    end else if (op == OP_I2B) begin
      nread = 3'd1;
      npop  = 3'd1;
      np    = 3'd1;
      res   = {1'b0, {24{v_q[0][7]}}, v_q[0][7:0]};
    end else if (op == OP_I2C) begin
      nread = 3'd1;
      npop  = 3'd1;
      np    = 3'd1;
      res   = {17'd0, v_q[0][15:0]};
    end else if (op == OP_I2S) begin
      nread = 3'd1;
      npop  = 3'd1;
      np    = 3'd1;
      res   = {1'b0, {16{v_q[0][15]}}, v_q[0][15:0]};
    end else if (op >= OP_LCMP && op <= OP_DCMPG) begin
      nread  = 3'd2;
      npop   = 3'd2;
      np     = 3'd1;
      alu_op = jbic_pkg::ALU_CMP;
      alu_a  = v_q[1][31:0];
      alu_b  = v_q[0][31:0];
      res    = {1'b0, alu_res};
    end else if (op >= OP_IFEQ && op <= OP_IFLE) begin
      nread  = 3'd1;
      npop   = 3'd1;
      alu_op = jbic_pkg::ALU_CMP;
      alu_a  = v_q[0][31:0];
      br     = 1'b1;
      take   = cond_take(3'(op - OP_IFEQ), alu_res);
    end else if (op >= OP_IF_ICMPEQ && op <= OP_IF_ICMPLE) begin
      nread  = 3'd2;
      npop   = 3'd2;
      alu_op = jbic_pkg::ALU_CMP;
      alu_a  = v_q[1][31:0];
      alu_b  = v_q[0][31:0];
      br     = 1'b1;
      take   = cond_take(3'(op - OP_IF_ICMPEQ), alu_res);
    end else if (op == OP_IF_ACMPEQ || op == OP_IF_ACMPNE) begin
      nread = 3'd2;
      npop  = 3'd2;
      br    = 1'b1;
      take  = (op == OP_IF_ACMPEQ) == (v_q[1][31:0] == v_q[0][31:0]);
    end else if (op == OP_GOTO) begin
      br   = 1'b1;
      take = 1'b1;
    end else if (op == OP_IFNULL || op == OP_IFNONNULL) begin
      nread = 3'd1;
      npop  = 3'd1;
      br    = 1'b1;
      take  = (op == OP_IFNULL) == (v_q[0] == REF_NULL);
    end else if (op == OP_GOTO_W) begin
      nxt = pc_q + {bt2, bt3};
    end else if (op == OP_JSR) begin
      np  = 3'd1;
      res = {17'd0, pc_q + 16'd3};
      nxt = pc_q + {bt0, bt1};
    end else if (op == OP_RET) begin
      if (lok) nxt = lval[15:0];
      else     fault = jbic_pkg::ST_BAD_LOCAL;
    end else if (op >= OP_IRETURN && op <= OP_ARETURN) begin
      nread  = 3'd1;
      npop   = 3'd1;
      is_ret = 1'b1;
      retv   = v_q[0][31:0];
    end else if (op == OP_RETURN) begin
      is_ret = 1'b1;
    end else if (op == OP_ATHROW) begin
      fault = jbic_pkg::ST_THROWN;
    end else if (op == OP_WIDE) begin
      nxt = pc_q + 16'd4;
      if (wop >= OP_ILOAD && wop <= OP_ALOAD) begin
        np  = {2'b0, lok};
        res = lval;
        if (!lok) fault = jbic_pkg::ST_BAD_LOCAL;
      end else if (wop >= OP_ISTORE && wop <= OP_ASTORE) begin
        nread = 3'd1;
        npop  = 3'd1;
        lwe   = lok;
        if (!lok) fault = jbic_pkg::ST_BAD_LOCAL;
      end else if (wop == OP_IINC) begin
        alu_a  = lval[31:0];
        alu_b  = {{16{bt3[7]}}, bt3, bt4};
        lwe    = lok;
        lwdata = {lval[32], alu_res};
        if (!lok) fault = jbic_pkg::ST_BAD_LOCAL;
        nxt    = pc_q + 16'd6;
      end else if (wop == OP_RET) begin
        if (lok) nxt = lval[15:0];
        else     fault = jbic_pkg::ST_BAD_LOCAL;
      end else begin
        fault = jbic_pkg::ST_UNSUP;
      end
    end else begin
      fault = jbic_pkg::ST_UNSUP;
    end
    if (br) nxt = take ? (pc_q + {bt0, bt1}) : (pc_q + 16'd3);
  end

  assign dpop = (depth_q > DW'(npop)) ? (depth_q - DW'(npop)) : '0;
  assign ovf  = ((DW + 1)'(dpop) + (DW + 1)'(np)) > (DW + 1)'(jbic_pkg::STACK_DEPTH);

  always_comb begin
    if (fault != jbic_pkg::ST_CONT)  st = fault;
    else if (ovf)                    st = jbic_pkg::ST_OVF;
    else if (is_ret)                 st = jbic_pkg::ST_RET;
    else                             st = jbic_pkg::ST_CONT;
  end

  always_comb begin
    case (src[wcnt_q])
      jbic_pkg::SRC_V1: stk_wdata = v_q[0];
      jbic_pkg::SRC_V2: stk_wdata = v_q[1];
      jbic_pkg::SRC_V3: stk_wdata = v_q[2];
      jbic_pkg::SRC_V4: stk_wdata = v_q[3];
      default:          stk_wdata = res_q;
    endcase
  end

  assign stk_raddr = AW'(depth_q - DW'(1) - DW'(rcnt_q));
  assign stk_waddr = AW'(dpop_q + DW'(wcnt_q));
  assign out_load  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    in_stall_o = (state_q != jbic_pkg::S_IDLE);
    alu_start = 1'b0;
    stk_we    = 1'b0;
    case (state_q)
      jbic_pkg::S_IDLE: begin
        if (in_valid_i) state_d = jbic_pkg::S_DEC;
      end
      jbic_pkg::S_DEC: begin
        if (item_q.action == jbic_pkg::ACT_EXEC && pc_q < code_len_q) begin
          state_d = jbic_pkg::S_READ;
        end else begin
          state_d = jbic_pkg::S_OUT;
        end
      end
      jbic_pkg::S_READ: begin
        if (rcnt_q == nread) state_d = jbic_pkg::S_EXEC;
      end
      jbic_pkg::S_EXEC: begin
        alu_start = 1'b1;
        state_d   = jbic_pkg::S_WAIT;
      end
      jbic_pkg::S_WAIT: begin
        if (alu_done) state_d = jbic_pkg::S_FIN;
      end
      jbic_pkg::S_FIN: begin
        if (st == jbic_pkg::ST_CONT && np != 3'd0) state_d = jbic_pkg::S_WRITE;
        else                                       state_d = jbic_pkg::S_OUT;
      end
      jbic_pkg::S_WRITE: begin
        stk_we = 1'b1;
        if (wcnt_q == np_q - 3'd1) state_d = jbic_pkg::S_OUT;
      end
      jbic_pkg::S_OUT: begin
        if (out_load) state_d = jbic_pkg::S_IDLE;
      end
      default: state_d = jbic_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jbic_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_len_q  <= '0;
      pc_q        <= '0;
      depth_q     <= '0;
      dpop_q      <= '0;
      out_valid_q <= 1'b0;
      rcnt_q      <= '0;
      wcnt_q      <= '0;
      np_q        <= '0;
      for (int k = 0; k < jbic_pkg::LOCAL_COUNT; k++) loc_q[k] <= '0;
    end else begin
      if (cfg_we_i) code_len_q <= cfg_wdata_i;
      if (state_q == jbic_pkg::S_OUT && out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i)                      out_valid_q <= 1'b0;
      case (state_q)
        jbic_pkg::S_DEC: begin
          rcnt_q <= '0;
          if (item_q.action == jbic_pkg::ACT_CLEAR) begin
            depth_q <= '0;
            pc_q    <= '0;
            for (int k = 0; k < jbic_pkg::LOCAL_COUNT; k++) loc_q[k] <= '0;
          end else if (item_q.action == jbic_pkg::ACT_LOAD &&
                       9'(item_q.local_index) < 9'(jbic_pkg::LOCAL_COUNT)) begin
            loc_q[item_q.local_index[LW-1:0]] <=
              {item_q.local_is_ref, 32'(item_q.local_value)};
          end
        end
        jbic_pkg::S_READ: begin
          if (rcnt_q != nread) rcnt_q <= rcnt_q + 3'd1;
        end
        jbic_pkg::S_FIN: begin
          wcnt_q <= '0;
          dpop_q <= dpop;
          if (st == jbic_pkg::ST_CONT) begin
            np_q    <= np;
            pc_q    <= nxt;
            depth_q <= dpop + DW'(np);
            if (lwe) loc_q[li[LW-1:0]] <= lwdata;
          end else begin
            np_q <= '0;
          end
        end
        jbic_pkg::S_WRITE: begin
          wcnt_q <= wcnt_q + 3'd1;
        end
        default: begin
          np_q <= np_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == jbic_pkg::S_IDLE && in_valid_i) item_q <= in_i;
    if (state_q == jbic_pkg::S_READ && rcnt_q != 3'd0) begin
      v_q[2'(rcnt_q - 3'd1)] <=
        (DW'(rcnt_q - 3'd1) < depth_q) ? stk_rdata : '0;
    end
    if (state_q == jbic_pkg::S_DEC) begin
      rsp_q.next_pc      <= (item_q.action == jbic_pkg::ACT_CLEAR) ? 16'd0 : pc_q;
      rsp_q.return_value <= '0;
      if (item_q.action == jbic_pkg::ACT_LOAD &&
          9'(item_q.local_index) >= 9'(jbic_pkg::LOCAL_COUNT)) begin
        rsp_q.status <= jbic_pkg::ST_BAD_LOCAL;
      end else if (item_q.action == jbic_pkg::ACT_EXEC) begin
        rsp_q.status <= jbic_pkg::ST_RET;
      end else begin
        rsp_q.status <= jbic_pkg::ST_CONT;
      end
    end
    if (state_q == jbic_pkg::S_FIN) begin
      res_q              <= res;
      rsp_q.status       <= st;
      rsp_q.next_pc      <= (st == jbic_pkg::ST_CONT) ? nxt : pc_q;
      rsp_q.return_value <= (st == jbic_pkg::ST_RET) ? $signed(retv) : '0;
    end
    if (state_q == jbic_pkg::S_OUT && out_load) out_q <= rsp_q;
  end

  jbic_stack u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  jbic_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .done_o  (alu_done),
    .res_o   (alu_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `JBIC_NEVER(a_depth_in_range, depth_q > DW'(jbic_pkg::STACK_DEPTH))
  `JBIC_ASSERT(a_alu_done_in_wait, alu_done |-> state_q == jbic_pkg::S_WAIT)
  `JBIC_ASSERT(a_accept_decodes, (in_valid_i && !in_stall_o) |=> state_q == jbic_pkg::S_DEC)

endmodule

### tb/java_bytecode_integer_core_tb.sv
// testbench of java_bytecode_integer_core: a directed table and then random bytecode streams,
// every result checked against a table entry or an in-bench model of frame, stack and pc
// depends on jbic_pkg and the block's rtl
`timescale 1ns / 100ps
module java_bytecode_integer_core_tb;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [7:0] OP_NOP = 8'h00, OP_ACONST_NULL = 8'h01, OP_ICONST_M1 = 8'h02;
  localparam logic [7:0] OP_ICONST_5 = 8'h08, OP_BIPUSH = 8'h10, OP_SIPUSH = 8'h11;
  localparam logic [7:0] OP_ILOAD = 8'h15, OP_ILOAD_0 = 8'h1a, OP_ILOAD_1 = 8'h1b;
  localparam logic [7:0] OP_ISTORE = 8'h36, OP_POP = 8'h57, OP_DUP = 8'h59;
  localparam logic [7:0] OP_IADD = 8'h60, OP_IDIV = 8'h6c, OP_IREM = 8'h70;
  localparam logic [7:0] OP_INEG = 8'h74, OP_IINC = 8'h84, OP_IFEQ = 8'h99;
  localparam logic [7:0] OP_IF_ICMPEQ = 8'h9f, OP_GOTO = 8'ha7, OP_JSR = 8'ha8;
  localparam logic [7:0] OP_RET = 8'ha9, OP_IRETURN = 8'hac, OP_RETURN = 8'hb1;
  localparam logic [7:0] OP_ATHROW = 8'hbf, OP_WIDE = 8'hc4, OP_IFNULL = 8'hc6;
  localparam logic [7:0] OP_GOTO_W = 8'hc8, OP_BAD = 8'hff;
  localparam logic [32:0] NULL_REF = 33'h1_0000_0000;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1300;

  typedef struct {
    jbic_pkg::in_t  item;
    bit             fixed;
    jbic_pkg::out_t want;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, cfg_we;
  logic out_stall = 1'b0;
  jbic_pkg::in_t  in_bus;
  jbic_pkg::out_t out_bus;
  logic [15:0] cfg_wdata;

  logic [32:0] stk[jbic_pkg::STACK_DEPTH];
  logic [32:0] loc[jbic_pkg::LOCAL_COUNT];
  int          depth;
  logic [15:0] pc_q, clen;
  int          fault;

  jbic_pkg::out_t results_due[$];
  int   err_count = 0;
  int   cycles = 0;
  int   checked = 0;
  int   calm;
  row_t rows[$];

  java_bytecode_integer_core u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_i(in_bus),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_o(out_bus),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [32:0] pop_e();
    if (depth == 0) return 33'd0;
    depth--;
    return stk[depth];
  endfunction

  function automatic void push_e(logic [32:0] v);
    if (depth >= jbic_pkg::STACK_DEPTH) begin
      if (fault == 0) fault = jbic_pkg::ST_OVF;
    end else begin
      stk[depth] = v;
      depth++;
    end
  endfunction

  function automatic bit slot_ok(int i);
    if (i >= jbic_pkg::LOCAL_COUNT) begin
      if (fault == 0) fault = jbic_pkg::ST_BAD_LOCAL;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int scmp(logic [31:0] a, logic [31:0] b);
    if ($signed(a) < $signed(b)) return -1;
    if ($signed(a) > $signed(b)) return 1;
    return 0;
  endfunction

  function automatic bit cond_hit(int sel, int c);
    case (sel)
      0: return c == 0;
      1: return c != 0;
      2: return c < 0;
      3: return c >= 0;
      4: return c > 0;
      default: return c <= 0;
    endcase
  endfunction

  function automatic logic [31:0] sx8(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic jbic_pkg::out_t step_frame(jbic_pkg::in_t x);
    jbic_pkg::out_t r;
    logic [7:0]  op, b0, b1, b2, b3, b4;
    logic [31:0] nxt, a, b, res, retv;
    logic [32:0] v1, v2, v3, v4, e;
    logic [32:0] ss[jbic_pkg::STACK_DEPTH];
    logic [32:0] sl[jbic_pkg::LOCAL_COUNT];
    int          st, d0, i;
    bit          take;
    longint      xl, yl;
    op = x.opcode;
    {b0, b1, b2, b3, b4} = x.following_bytes;
    nxt = {16'd0, pc_q};
    st = jbic_pkg::ST_CONT;
    retv = 0;
    if (x.action == jbic_pkg::ACT_CLEAR) begin
      depth = 0;
      foreach (loc[k]) loc[k] = 33'd0;
      pc_q = 0;
      nxt = 0;
    end else if (x.action == jbic_pkg::ACT_LOAD) begin
      if (x.local_index < jbic_pkg::LOCAL_COUNT)
        loc[x.local_index] = {x.local_is_ref, x.local_value};
      else st = jbic_pkg::ST_BAD_LOCAL;
    end else if (x.action == jbic_pkg::ACT_EXEC) begin
      if (pc_q >= clen) begin
        st = jbic_pkg::ST_RET;
      end else begin
        d0 = depth; ss = stk; sl = loc; fault = 0;
        nxt = pc_q + 1;
        if (op == OP_NOP || (op >= 8'h85 && op <= 8'h90)) begin
        end else if (op == OP_ACONST_NULL) push_e(NULL_REF);
        else if (op >= OP_ICONST_M1 && op <= OP_ICONST_5) push_e({1'b0, 32'(op) - 32'd3});
        else if (op >= 8'h09 && op <= 8'h0a) push_e({1'b0, 32'(op - 8'h09)});
        else if (op >= 8'h0b && op <= 8'h0d) push_e({1'b0, 32'(op - 8'h0b)});
        else if (op >= 8'h0e && op <= 8'h0f) push_e({1'b0, 32'(op - 8'h0e)});
        else if (op == OP_BIPUSH) begin
          push_e({1'b0, sx8(b0)}); nxt = pc_q + 2;
        end else if (op == OP_SIPUSH) begin
          push_e({1'b0, sx16({b0, b1})}); nxt = pc_q + 3;
        end else if (op >= OP_ILOAD && op <= 8'h19) begin
          if (slot_ok(b0)) push_e(loc[b0]);
          nxt = pc_q + 2;
        end else if (op >= OP_ILOAD_0 && op <= 8'h2d) push_e(loc[(op - OP_ILOAD_0) & 3]);
        else if (op >= OP_ISTORE && op <= 8'h3a) begin
          v1 = pop_e();
          if (slot_ok(b0)) loc[b0] = v1;
          nxt = pc_q + 2;
        end else if (op >= 8'h3b && op <= 8'h4e) loc[(op - 8'h3b) & 3] = pop_e();
        else if (op == OP_POP) v1 = pop_e();
        else if (op == 8'h58) begin
          v1 = pop_e(); v1 = pop_e();
        end else if (op == OP_DUP) begin
          v1 = (depth != 0) ? stk[depth - 1] : 33'd0;
          push_e(v1);
        end else if (op == 8'h5a) begin
          v1 = pop_e(); v2 = pop_e();
          push_e(v1); push_e(v2); push_e(v1);
        end else if (op == 8'h5b) begin
          v1 = pop_e(); v2 = pop_e(); v3 = pop_e();
          push_e(v1); push_e(v3); push_e(v2); push_e(v1);
        end else if (op == 8'h5c) begin
          v1 = pop_e(); v2 = pop_e();
          push_e(v2); push_e(v1); push_e(v2); push_e(v1);
        end else if (op == 8'h5d) begin
          v1 = pop_e(); v2 = pop_e(); v3 = pop_e();
          push_e(v2); push_e(v1); push_e(v3); push_e(v2); push_e(v1);
        end else if (op == 8'h5e) begin
          v1 = pop_e(); v2 = pop_e(); v3 = pop_e(); v4 = pop_e();
          push_e(v2); push_e(v1); push_e(v4); push_e(v3); push_e(v2); push_e(v1);
        end else if (op == 8'h5f) begin
          v1 = pop_e(); v2 = pop_e();
          push_e(v1); push_e(v2);
        end else if (op >= OP_IADD && op <= 8'h83 && !(op >= OP_INEG && op <= 8'h77)) begin
          v1 = pop_e(); v2 = pop_e();
          b = v1[31:0]; a = v2[31:0]; res = 0;
          if (op <= 8'h63) res = a + b;
          else if (op <= 8'h67) res = a - b;
          else if (op <= 8'h6b) res = a * b;
          else if (op <= 8'h73) begin
            if (b == 0) fault = jbic_pkg::ST_DIV0;
            else begin
              xl = longint'($signed(a)); yl = longint'($signed(b));
              res = (op < OP_IREM) ? 32'(xl / yl) : 32'(xl % yl);
            end
          end else if (op <= 8'h79) res = a << b[4:0];
          else if (op <= 8'h7b) res = $signed(a) >>> b[4:0];
          else if (op <= 8'h7d) res = a >> b[4:0];
          else if (op <= 8'h7f) res = a & b;
          else if (op <= 8'h81) res = a | b;
          else res = a ^ b;
          if (fault == 0) push_e({1'b0, res});
        end else if (op >= OP_INEG && op <= 8'h77) begin
          v1 = pop_e(); push_e({1'b0, 32'd0 - v1[31:0]});
        end else if (op == OP_IINC) begin
          if (slot_ok(b0)) begin
            e = loc[b0];
            loc[b0] = {e[32], e[31:0] + sx8(b1)};
          end
          nxt = pc_q + 3;
        end else if (op == 8'h91) begin
          v1 = pop_e(); push_e({1'b0, sx8(v1[7:0])});
        end else if (op == 8'h92) begin
          v1 = pop_e(); push_e({17'd0, v1[15:0]});
        end else if (op == 8'h93) begin
          v1 = pop_e(); push_e({1'b0, sx16(v1[15:0])});
        end else if (op >= 8'h94 && op <= 8'h98) begin
          v1 = pop_e(); v2 = pop_e();
          push_e({1'b0, 32'(scmp(v2[31:0], v1[31:0]))});
        end else if ((op >= OP_IFEQ && op <= OP_GOTO) || op == OP_IFNULL || op == 8'hc7) begin
          if (op < OP_IF_ICMPEQ) begin
            v1 = pop_e(); take = cond_hit(op - OP_IFEQ, scmp(v1[31:0], 0));
          end else if (op <= 8'ha4) begin
            v1 = pop_e(); v2 = pop_e();
            take = cond_hit(op - OP_IF_ICMPEQ, scmp(v2[31:0], v1[31:0]));
          end else if (op <= 8'ha6) begin
            v1 = pop_e(); v2 = pop_e();
            take = (op == 8'ha5) == (v1[31:0] == v2[31:0]);
          end else if (op == OP_GOTO) take = 1'b1;
          else begin
            v1 = pop_e(); take = (op == OP_IFNULL) == (v1 == NULL_REF);
          end
          nxt = take ? pc_q + sx16({b0, b1}) : pc_q + 3;
        end else if (op == OP_GOTO_W) nxt = pc_q + {b0, b1, b2, b3};
        else if (op == OP_JSR) begin
          push_e({17'd0, pc_q + 16'd3});
          nxt = pc_q + sx16({b0, b1});
        end else if (op == OP_RET) begin
          if (slot_ok(b0)) nxt = loc[b0][31:0];
        end else if (op >= OP_IRETURN && op <= 8'hb0) begin
          v1 = pop_e(); retv = v1[31:0]; st = jbic_pkg::ST_RET;
        end else if (op == OP_RETURN) st = jbic_pkg::ST_RET;
        else if (op == OP_ATHROW) fault = jbic_pkg::ST_THROWN;
        else if (op == OP_WIDE) begin
          i = {b1, b2};
          nxt = pc_q + 4;
          if (b0 >= OP_ILOAD && b0 <= 8'h19) begin
            if (slot_ok(i)) push_e(loc[i]);
          end else if (b0 >= OP_ISTORE && b0 <= 8'h3a) begin
            v1 = pop_e();
            if (slot_ok(i)) loc[i] = v1;
          end else if (b0 == OP_IINC) begin
            if (slot_ok(i)) begin
              e = loc[i];
              loc[i] = {e[32], e[31:0] + sx16({b3, b4})};
            end
            nxt = pc_q + 6;
          end else if (b0 == OP_RET) begin
            if (slot_ok(i)) nxt = loc[i][31:0];
          end else fault = jbic_pkg::ST_UNSUP;
        end else fault = jbic_pkg::ST_UNSUP;
        if (fault != 0) st = fault;
        if (st != jbic_pkg::ST_CONT) begin
          stk = ss; loc = sl; depth = d0;
          nxt = pc_q;
        end else pc_q = nxt[15:0];
      end
    end
    r.next_pc = nxt[15:0];
    r.status = st[2:0];
    r.return_value = (st == jbic_pkg::ST_RET) ? retv : 32'd0;
    return r;
  endfunction

  function automatic jbic_pkg::in_t mk(logic [1:0] act, logic [7:0] op, logic [39:0] fb,
                                       logic [7:0] idx, logic [31:0] val, logic is_ref);
    jbic_pkg::in_t x;
    x.action = act; x.opcode = op; x.following_bytes = fb;
    x.local_index = idx; x.local_value = val; x.local_is_ref = is_ref;
    return x;
  endfunction

  function automatic jbic_pkg::out_t res(logic [15:0] pc, jbic_pkg::status_e st,
                                         logic [31:0] rv);
    jbic_pkg::out_t r;
    r.next_pc = pc; r.status = st; r.return_value = rv;
    return r;
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 11))
      0, 1:    return 8'($urandom_range(OP_ACONST_NULL, OP_SIPUSH));
      2:       return 8'($urandom_range(OP_ILOAD, 8'h2d));
      3:       return 8'($urandom_range(OP_ISTORE, 8'h4e));
      4:       return 8'($urandom_range(OP_POP, 8'h5f));
      5, 6:    return 8'($urandom_range(OP_IADD, 8'h83));
      7:       return 8'($urandom_range(OP_IINC, 8'h98));
      8:       return 8'($urandom_range(OP_IFEQ, OP_RET));
      9:       case ($urandom_range(0, 5))
                 0: return OP_WIDE;
                 1: return OP_IFNULL;
                 2: return 8'hc7;
                 3: return OP_GOTO_W;
                 4: return OP_ATHROW;
                 default: return 8'($urandom_range(OP_IRETURN, OP_RETURN));
               endcase
      10:      return OP_NOP;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic jbic_pkg::in_t rand_item();
    jbic_pkg::in_t x;
    logic [39:0] fb;
    int n;
    fb = {$urandom(), 8'($urandom())};
    if ($urandom_range(0, 99) < 85) fb[39:36] = 4'd0;
    x = mk(jbic_pkg::ACT_EXEC, pick_op(), fb, 8'($urandom()), $urandom(),
           1'($urandom_range(0, 1)));
    if ($urandom_range(0, 99) < 80) x.local_index[7:4] = 4'd0;
    if (x.opcode == OP_WIDE) begin
      case ($urandom_range(0, 4))
        0: x.following_bytes[39:32] = OP_ILOAD;
        1: x.following_bytes[39:32] = OP_ISTORE;
        2: x.following_bytes[39:32] = OP_IINC;
        3: x.following_bytes[39:32] = OP_RET;
        default: x.following_bytes[39:32] = 8'($urandom());
      endcase
      if ($urandom_range(0, 99) < 85) x.following_bytes[31:20] = 12'd0;
    end
    n = $urandom_range(0, 99);
    if (n < 2) x.action = jbic_pkg::ACT_CLEAR;
    else if (n < 10) x.action = jbic_pkg::ACT_LOAD;
    else if (n < 12) x.action = ACT_NONE;
    return x;
  endfunction

  task automatic send(jbic_pkg::in_t x, bit fixed, jbic_pkg::out_t want);
    jbic_pkg::out_t p;
    while (calm == 0 && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      in_bus <= mk(2'($urandom()), 8'($urandom()), {$urandom(), 8'($urandom())},
                   8'($urandom()), $urandom(), 1'($urandom()));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bus <= x;
    do @(posedge clk); while (in_stall);
    p = step_frame(x);
    results_due.push_back(fixed ? want : p);
  endtask

  task automatic set_code_length(logic [15:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    clen = v;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      checked++;
      if (results_due.size() == 0) begin
        err_count++;
        $display("%0t: unexpected item, actual %h", $time, out_bus);
      end else begin
        jbic_pkg::out_t w;
        w = results_due.pop_front();
        if (w.next_pc !== out_bus.next_pc) begin
          err_count++;
          $display("%0t: next_pc expected %h actual %h", $time, w.next_pc, out_bus.next_pc);
        end
        if (w.status !== out_bus.status) begin
          err_count++;
          $display("%0t: status expected %0d actual %0d", $time, w.status, out_bus.status);
        end
        if (w.return_value !== out_bus.return_value) begin
          err_count++;
          $display("%0t: return_value expected %h actual %h", $time, w.return_value,
                   out_bus.return_value);
        end
      end
    end
    out_stall <= (calm == 0) && ($urandom_range(0, 99) < 34);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("java_bytecode_integer_core verification failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] lens[5];
    jbic_pkg::out_t none;
    lens = '{16'hffff, 16'd0, 16'd1, 16'h8000, 16'd300};
    none = res(0, jbic_pkg::ST_CONT, 0);
    calm = 0;
    depth = 0; pc_q = 0; clen = 0;
    foreach (stk[k]) stk[k] = 33'd0;
    foreach (loc[k]) loc[k] = 33'd0;
    rst_n = 1'b0; in_valid = 1'b0; cfg_we = 1'b0; cfg_wdata = 16'd0;
    in_bus = mk(jbic_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    send(mk(jbic_pkg::ACT_EXEC, OP_ICONST_5, 0, 0, 0, 0), 1'b1, res(0, jbic_pkg::ST_RET, 0));
    set_code_length(16'hffff);
    rows.push_back('{mk(jbic_pkg::ACT_CLEAR, 0, 0, 0, 0, 0), 1,
                     res(0, jbic_pkg::ST_CONT, 0)});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_ATHROW, 0, 0, 0, 0), 1,
                     res(0, jbic_pkg::ST_THROWN, 0)});
    rows.push_back('{mk(jbic_pkg::ACT_LOAD, 0, 0, 8'hff, 32'h7fffffff, 0), 1,
                     res(0, jbic_pkg::ST_BAD_LOCAL, 0)});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_BAD, 0, 0, 0, 0), 1,
                     res(0, jbic_pkg::ST_UNSUP, 0)});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_WIDE, {OP_IADD, 32'd0}, 0, 0, 0), 1,
                     res(0, jbic_pkg::ST_UNSUP, 0)});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_ILOAD, {8'd200, 32'd0}, 0, 0, 0), 1,
                     res(0, jbic_pkg::ST_BAD_LOCAL, 0)});
    rows.push_back('{mk(ACT_NONE, 0, 0, 0, 0, 0), 1, res(0, jbic_pkg::ST_CONT, 0)});
    rows.push_back('{mk(jbic_pkg::ACT_LOAD, 0, 0, 0, 32'h80000000, 0), 1,
                     res(0, jbic_pkg::ST_CONT, 0)});
    rows.push_back('{mk(jbic_pkg::ACT_LOAD, 0, 0, 1, 32'hffffffff, 0), 1,
                     res(0, jbic_pkg::ST_CONT, 0)});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_ILOAD_0, 0, 0, 0, 0), 1,
                     res(1, jbic_pkg::ST_CONT, 0)});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_ILOAD_1, 0, 0, 0, 0), 1,
                     res(2, jbic_pkg::ST_CONT, 0)});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_IDIV, 0, 0, 0, 0), 1,
                     res(3, jbic_pkg::ST_CONT, 0)});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_IRETURN, 0, 0, 0, 0), 1,
                     res(3, jbic_pkg::ST_RET, 32'h80000000)});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_ILOAD_0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_ILOAD_1, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_IREM, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_ICONST_M1 + 8'd1, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_IDIV, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(jbic_pkg::ACT_CLEAR, 0, 0, 0, 0, 0), 1,
                     res(0, jbic_pkg::ST_CONT, 0)});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_IADD, 0, 0, 0, 0), 1,
                     res(1, jbic_pkg::ST_CONT, 0)});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_ACONST_NULL, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_IFNULL, 40'h8000_0000_00, 0, 0, 0), 0, none});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_SIPUSH, 40'h8000_0000_00, 0, 0, 0), 0, none});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_JSR, 40'h7fff_0000_00, 0, 0, 0), 0, none});
    rows.push_back('{mk(jbic_pkg::ACT_EXEC, OP_GOTO_W, 40'hffff_ffff_ff, 0, 0, 0), 0, none});
    foreach (rows[k]) send(rows[k].item, rows[k].fixed, rows[k].want);

    // random streams over several code lengths
    for (int ph = 0; ph < 5; ph++) begin
      set_code_length(lens[ph]);
      send(mk(jbic_pkg::ACT_CLEAR, 0, 0, 0, 0, 0), 1'b0, none);
      for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
        calm = (ph == 0 && n >= 120 && n < 200);
        send(rand_item(), 1'b0, none);
      end
      calm = 0;
    end
    set_code_length(16'd0);
    send(mk(jbic_pkg::ACT_EXEC, OP_NOP, 0, 0, 0, 0), 1'b0, none);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("ran the directed table and %0d random items over five code lengths,",
             RANDOM_ITEMS);
    $display("%0d results checked with %0d mismatches", checked, err_count);
    if (err_count == 0 && results_due.size() == 0) begin
      $display("java_bytecode_integer_core verification clean");
    end else begin
      $display("java_bytecode_integer_core verification failed");
    end
    $finish;
  end

endmodule

### java_bytecode_integer_core.f
+incdir+sv
sv/jbic_pkg.sv
sv/jbic_stack.sv
sv/jbic_alu.sv
sv/java_bytecode_integer_core.sv
tb/java_bytecode_integer_core_tb.sv
